// ===== rtl/intel_hex_record_parser_defines.svh =====
// Assertion macros for the Intel HEX record parser RTL, used by the result sequencer.
`ifndef INTEL_HEX_RECORD_PARSER_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_DEFINES_SVH

// Plain property, checked at every rising clock edge outside reset.
`define IHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define IHP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IHP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ihp_pkg.sv =====
// Shared constants, types and queue entry format for the Intel HEX record parser.
package ihp_pkg;

  localparam int AddrWidth = 32;
  localparam logic [31:0] AddrMask = 32'hFFFF_FFFF >> (32 - AddrWidth);
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharZero  = 8'h30;

  localparam logic [7:0] RecData   = 8'h00;
  localparam logic [7:0] RecEof    = 8'h01;
  localparam logic [7:0] RecExtSeg = 8'h02;
  localparam logic [7:0] RecExtLin = 8'h04;

  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindExtent = 2'd1,
    KindNoData = 2'd2
  } kind_e;

  // One accepted character's worth of results.
  typedef struct packed {
    logic        has_data;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        has_sum;
    logic [31:0] lowest;
    logic [31:0] highest;
  } q_entry_t;

endpackage

// ===== rtl/intel_hex_record_parser.sv =====
// A request is written into the queue when it is accepted, then loaded into the output register.
// Throughput: one character per cycle while the queue is not full; a character that yields a
// data byte and a summary presents the data byte first and then the summary, held in a pending register.
// The four-entry queue absorbs output stalls; the input stalls only when it is full.
// Reset: rst_ni clears parser state, queue pointers and output valid at once (asynchronous).
// End of input also returns the parser to its reset state after the summary is queued.
module intel_hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel: one character per request
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        end_of_input_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] byte_address_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] image_base_o,
  output logic [31:0] image_size_o,
  output logic        final_res_o
);

  logic              push;
  ihp_pkg::q_entry_t push_entry;
  logic              pop;
  ihp_pkg::q_entry_t head;
  logic              q_full;
  logic              q_empty;

  // Stall the request side only on a full queue, never on the output handshake.
  assign in_stall_o = q_full;

  // Front end: framing, field decode, segment base and image extent.
  ihp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .character_i    (character_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  // Queue: hold decoded requests so the two sides stall independently.
  ihp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  // Back end: emit the data byte first, then the summary, with final_res on the last.
  ihp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_empty_i      (q_empty),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .byte_address_o (byte_address_o),
    .data_byte_o    (data_byte_o),
    .image_base_o   (image_base_o),
    .image_size_o   (image_size_o),
    .final_res_o    (final_res_o)
  );

endmodule

// ===== rtl/ihp_front.sv =====
// Character parser: record framing, field decode, base and extent tracking.
module ihp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        character_i,
  input  logic              end_of_input_i,
  input  logic              q_full_i,
  output logic              push_o,
  output ihp_pkg::q_entry_t push_entry_o
);

  localparam logic [2:0] PhLineStart = 3'd0;
  localparam logic [2:0] PhSkip      = 3'd1;
  localparam logic [2:0] PhHeader    = 3'd2;
  localparam logic [2:0] PhData      = 3'd3;
  localparam logic [2:0] PhBase      = 3'd4;
  localparam logic [2:0] PhTail      = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hi_nib_q, hi_nib_d;
  logic        nsel_q, nsel_d;
  logic [8:0]  fidx_q, fidx_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  rtype_q, rtype_d;
  logic [15:0] offset_q, offset_d;
  logic [7:0]  bval_q, bval_d;
  logic [31:0] seg_q, seg_d;
  logic [31:0] lowest_q, lowest_d;
  logic [31:0] highest_q, highest_d;

  logic        acc;
  logic        line_end;
  logic [7:0]  digit;
  logic [7:0]  byte_val;
  logic [31:0] start;
  logic [32:0] end_sum;
  logic [31:0] end_v;
  logic [15:0] base_val;

  assign acc      = in_valid_i && !q_full_i;
  assign line_end = (character_i == ihp_pkg::CharLf) || (character_i == ihp_pkg::CharCr);

  always_comb begin
    if (character_i >= ihp_pkg::CharLowA) begin
      digit = character_i - ihp_pkg::CharLowA + 8'd10;
    end else if (character_i >= ihp_pkg::CharUpA) begin
      digit = character_i - ihp_pkg::CharUpA + 8'd10;
    end else begin
      digit = character_i - ihp_pkg::CharZero;
    end
  end

  assign byte_val = {hi_nib_q, 4'h0} | digit;
  assign start    = (seg_q + {16'h0, offset_q}) & ihp_pkg::AddrMask;
  assign end_sum  = {1'b0, start} + {25'h0, count_q};
  assign end_v    = (end_sum > {1'b0, ihp_pkg::AddrMask}) ? ihp_pkg::AddrMask : end_sum[31:0];
  assign base_val = {bval_q, byte_val};

  always_comb begin
    phase_d   = phase_q;
    hi_nib_d  = hi_nib_q;
    nsel_d    = nsel_q;
    fidx_d    = fidx_q;
    count_d   = count_q;
    rtype_d   = rtype_q;
    offset_d  = offset_q;
    bval_d    = bval_q;
    seg_d     = seg_q;
    lowest_d  = lowest_q;
    highest_d = highest_q;
    push_entry_o.has_data = 1'b0;
    push_entry_o.addr     = (seg_q + {16'h0, offset_q} + {23'h0, fidx_q}) & ihp_pkg::AddrMask;
    push_entry_o.data     = byte_val;

    if (acc) begin
      if (line_end) begin
        phase_d = PhLineStart;
        nsel_d  = 1'b0;
      end else if (phase_q == PhLineStart) begin
        if (character_i == ihp_pkg::CharColon) begin
          phase_d = PhHeader;
          fidx_d  = 9'd0;
          nsel_d  = 1'b0;
        end else begin
          phase_d = PhSkip;
        end
      end else if (phase_q == PhHeader || phase_q == PhData || phase_q == PhBase) begin
        if (!nsel_q) begin
          hi_nib_d = digit[3:0];
          nsel_d   = 1'b1;
        end else begin
          nsel_d = 1'b0;
          if (phase_q == PhHeader) begin
            case (fidx_q)
              9'd0:    count_d = byte_val;
              9'd1:    offset_d = {byte_val, offset_q[7:0]};
              9'd2:    offset_d = {offset_q[15:8], byte_val};
              default: rtype_d = byte_val;
            endcase
            if (fidx_q >= 9'd3) begin
              // header complete: type byte decides what follows
              fidx_d = 9'd0;
              if (byte_val == ihp_pkg::RecData) begin
                if (start < lowest_q) lowest_d = start;
                if (end_v > highest_q) highest_d = end_v;
                phase_d = (count_q == 8'd0) ? PhTail : PhData;
              end else if (byte_val == ihp_pkg::RecEof) begin
                seg_d   = 32'h0;
                phase_d = PhTail;
              end else if (byte_val == ihp_pkg::RecExtSeg || byte_val == ihp_pkg::RecExtLin) begin
                phase_d = PhBase;
              end else begin
                phase_d = PhTail;
              end
            end else begin
              fidx_d = fidx_q + 9'd1;
            end
          end else if (phase_q == PhData) begin
            push_entry_o.has_data = 1'b1;
            fidx_d = fidx_q + 9'd1;
            if (fidx_d >= {1'b0, count_q}) phase_d = PhTail;
          end else begin
            if (fidx_q == 9'd0) begin
              bval_d = byte_val;
              fidx_d = 9'd1;
            end else begin
              if (rtype_q == ihp_pkg::RecExtSeg) begin
                seg_d = {12'h0, base_val, 4'h0} & ihp_pkg::AddrMask;
              end else begin
                seg_d = {base_val, 16'h0} & ihp_pkg::AddrMask;
              end
              phase_d = PhTail;
            end
          end
        end
      end
    end

    push_entry_o.has_sum = end_of_input_i;
    push_entry_o.lowest  = lowest_d;
    push_entry_o.highest = highest_d;

    // end of input: summary takes the extent above, then start a fresh stream
    if (acc && end_of_input_i) begin
      phase_d   = PhLineStart;
      hi_nib_d  = 4'h0;
      nsel_d    = 1'b0;
      fidx_d    = 9'd0;
      count_d   = 8'h0;
      rtype_d   = 8'h0;
      offset_d  = 16'h0;
      bval_d    = 8'h0;
      seg_d     = 32'h0;
      lowest_d  = ihp_pkg::AllOnes;
      highest_d = 32'h0;
    end
  end

  assign push_o = acc && (push_entry_o.has_data || end_of_input_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLineStart;
      hi_nib_q  <= 4'h0;
      nsel_q    <= 1'b0;
      fidx_q    <= 9'd0;
      count_q   <= 8'h0;
      rtype_q   <= 8'h0;
      offset_q  <= 16'h0;
      bval_q    <= 8'h0;
      seg_q     <= 32'h0;
      lowest_q  <= ihp_pkg::AllOnes;
      highest_q <= 32'h0;
    end else begin
      phase_q   <= phase_d;
      hi_nib_q  <= hi_nib_d;
      nsel_q    <= nsel_d;
      fidx_q    <= fidx_d;
      count_q   <= count_d;
      rtype_q   <= rtype_d;
      offset_q  <= offset_d;
      bval_q    <= bval_d;
      seg_q     <= seg_d;
      lowest_q  <= lowest_d;
      highest_q <= highest_d;
    end
  end

endmodule

// ===== rtl/ihp_queue.sv =====
// Short request queue between the parser and the result sequencer.
module ihp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ihp_pkg::q_entry_t push_entry_i,
  input  logic              pop_i,
  output ihp_pkg::q_entry_t head_o,
  output logic              full_o,
  output logic              empty_o
);

  ihp_pkg::q_entry_t entries_q [ihp_pkg::QueueDepth];
  logic [ihp_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ihp_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ihp_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == ihp_pkg::QCntW'(ihp_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == ihp_pkg::QPtrW'(ihp_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == ihp_pkg::QPtrW'(ihp_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/ihp_back.sv =====
// Result sequencer: splits queued requests into result items behind an output register.
`include "intel_hex_record_parser_defines.svh"

module ihp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ihp_pkg::q_entry_t head_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [1:0]        kind_o,
  output logic [31:0]       byte_address_o,
  output logic [7:0]        data_byte_o,
  output logic [31:0]       image_base_o,
  output logic [31:0]       image_size_o,
  output logic              final_res_o
);

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic [31:0] base_q, base_d;
  logic [31:0] size_q, size_d;
  logic        final_res_q, final_res_d;
  logic        pend_q, pend_d;
  logic [1:0]  pend_kind_q, pend_kind_d;
  logic [31:0] pend_base_q, pend_base_d;
  logic [31:0] pend_size_q, pend_size_d;

  logic        can_load;
  logic        no_data;
  logic [1:0]  sum_kind;
  logic [31:0] sum_base;
  logic [31:0] sum_size;

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    no_data = (head_i.lowest == ihp_pkg::AllOnes) || (head_i.highest == 32'h0) ||
              (head_i.highest <= head_i.lowest);
    if (no_data) begin
      sum_kind = ihp_pkg::KindNoData;
      sum_base = 32'h0;
      sum_size = 32'h0;
    end else begin
      sum_kind = ihp_pkg::KindExtent;
      sum_base = head_i.lowest;
      sum_size = head_i.highest - head_i.lowest;
    end
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    data_d      = data_q;
    base_d      = base_q;
    size_d      = size_q;
    final_res_d = final_res_q;
    pend_d      = pend_q;
    pend_kind_d = pend_kind_q;
    pend_base_d = pend_base_q;
    pend_size_d = pend_size_q;
    if (can_load) begin
      if (pend_q) begin
        // summary held back behind its data byte
        out_valid_d = 1'b1;
        kind_d      = pend_kind_q;
        addr_d      = 32'h0;
        data_d      = 8'h0;
        base_d      = pend_base_q;
        size_d      = pend_size_q;
        final_res_d = 1'b1;
        pend_d      = 1'b0;
      end else if (!q_empty_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        if (head_i.has_data) begin
          kind_d      = ihp_pkg::KindData;
          addr_d      = head_i.addr;
          data_d      = head_i.data;
          base_d      = 32'h0;
          size_d      = 32'h0;
          final_res_d = !head_i.has_sum;
          pend_d      = head_i.has_sum;
          pend_kind_d = sum_kind;
          pend_base_d = sum_base;
          pend_size_d = sum_size;
        end else begin
          kind_d      = sum_kind;
          addr_d      = 32'h0;
          data_d      = 8'h0;
          base_d      = sum_base;
          size_d      = sum_size;
          final_res_d = 1'b1;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    addr_q      <= addr_d;
    data_q      <= data_d;
    base_q      <= base_d;
    size_q      <= size_d;
    final_res_q <= final_res_d;
    pend_kind_q <= pend_kind_d;
    pend_base_q <= pend_base_d;
    pend_size_q <= pend_size_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign byte_address_o = addr_q;
  assign data_byte_o    = data_q;
  assign image_base_o   = base_q;
  assign image_size_o   = size_q;
  assign final_res_o    = final_res_q;

  `IHP_ASSERT_IMP(a_pend_behind_data, pend_q, out_valid_q && !final_res_q && kind_q == ihp_pkg::KindData, "pending summary without its data byte")
  `IHP_ASSERT_IMP(a_summary_is_final, out_valid_q && kind_q != ihp_pkg::KindData, final_res_q, "summary not marked final")
  `IHP_ASSERT(a_no_pop_while_pend, !(pop_o && pend_q), "queue popped while a summary is pending")
  `IHP_ASSERT_NXT(a_stall_keeps_pend, out_valid_q && out_stall_i && pend_q, pend_q, "pending summary lost under stall")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Intel HEX record parser: directed and random text streams.
`timescale 1ns / 1ps

module tb;

  // Run-time bounds: the cycle limit is several times the slowest legal run.
  localparam int CycleLimit = 400000;
  localparam int RandomChars = 1350;
  localparam int DrainCycles = 20;
  localparam int HoldCycles = 300;
  localparam int HoldAfter = 400;
  localparam int MaxWait = 18;

  // Where the parser stands within a line.
  typedef enum logic [2:0] {
    AtLineStart,
    SkipLine,
    InHeader,
    InData,
    InBase,
    InTail
  } parse_phase_e;

  // One request: a character and its end-of-input flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } hex_char_t;

  // One result as the block should present it.
  typedef struct {
    ihp_pkg::kind_e kind;
    logic [31:0]    addr;
    logic [7:0]     data;
    logic [31:0]    base;
    logic [31:0]    size;
    logic           last;
  } hex_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  character_i = '0;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] byte_address_o;
  logic [7:0]  data_byte_o;
  logic [31:0] image_base_o;
  logic [31:0] image_size_o;
  logic        final_res_o;

  intel_hex_record_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .character_i    (character_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .byte_address_o (byte_address_o),
    .data_byte_o    (data_byte_o),
    .image_base_o   (image_base_o),
    .image_size_o   (image_size_o),
    .final_res_o    (final_res_o)
  );

  // Stimulus and expectation stores.
  hex_char_t   pending_chars[$];
  hex_result_t expected_results[$];
  logic [7:0]  line_buf[$];

  // Handshake flags, sampled at the rising edge and read by the falling-edge drivers.
  logic req_taken = 1'b0;
  logic res_taken = 1'b0;
  logic rx_hold = 1'b0;
  bit   tx_drained = 1'b0;
  int   requests_taken = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // Predictor state, a private copy of what the parser holds.
  parse_phase_e phase_q;
  logic [7:0]   hi_nib;
  logic         nib_sel;
  logic [8:0]   field_idx;
  logic [7:0]   rec_count;
  logic [7:0]   rec_type;
  logic [15:0]  rec_offset;
  logic [7:0]   base_hi;
  logic [31:0]  seg_base;
  logic [31:0]  lowest_start;
  logic [31:0]  highest_end;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return the parser to its post-reset state; also done after every summary.
  function automatic void clear_parser();
    phase_q      = AtLineStart;
    hi_nib       = '0;
    nib_sel      = 1'b0;
    field_idx    = '0;
    rec_count    = '0;
    rec_type     = '0;
    rec_offset   = '0;
    base_hi      = '0;
    seg_base     = '0;
    lowest_start = ihp_pkg::AllOnes;
    highest_end  = '0;
  endfunction

  // Act on a complete header: update the extent for data records, clear the
  // base for end-of-file records, and pick the next phase.
  function automatic void finish_header();
    logic [31:0] start;
    logic [32:0] stop;
    start = (seg_base + {16'h0, rec_offset}) & ihp_pkg::AddrMask;
    field_idx = '0;
    case (rec_type)
      ihp_pkg::RecData: begin
        // The end saturates at the top of the address space.
        stop = {1'b0, start} + {25'h0, rec_count};
        if (stop > {1'b0, ihp_pkg::AddrMask}) stop = {1'b0, ihp_pkg::AddrMask};
        if (start < lowest_start) lowest_start = start;
        if (stop[31:0] > highest_end) highest_end = stop[31:0];
        phase_q = (rec_count == 8'd0) ? InTail : InData;
      end
      ihp_pkg::RecEof: begin
        seg_base = '0;
        phase_q = InTail;
      end
      ihp_pkg::RecExtSeg, ihp_pkg::RecExtLin: phase_q = InBase;
      default: phase_q = InTail;
    endcase
  endfunction

  // Advance the predictor by one accepted character and queue the results it causes.
  function automatic void decode_hex_char(logic [7:0] ch, logic eoi);
    logic [7:0]  nib;
    logic [7:0]  b;
    logic [15:0] val;
    int          before_cnt;
    before_cnt = expected_results.size();
    if (ch == ihp_pkg::CharLf || ch == ihp_pkg::CharCr) begin
      // A line end closes whatever record is open, even part-way through.
      phase_q = AtLineStart;
      nib_sel = 1'b0;
    end else if (phase_q == AtLineStart) begin
      if (ch == ihp_pkg::CharColon) begin
        phase_q = InHeader;
        field_idx = '0;
        nib_sel = 1'b0;
      end else begin
        phase_q = SkipLine;
      end
    end else if (phase_q == InHeader || phase_q == InData || phase_q == InBase) begin
      // Any character decodes as a digit here, hex or not, by plain subtraction.
      if (ch >= ihp_pkg::CharLowA) nib = ch - ihp_pkg::CharLowA + 8'd10;
      else if (ch >= ihp_pkg::CharUpA) nib = ch - ihp_pkg::CharUpA + 8'd10;
      else nib = ch - ihp_pkg::CharZero;
      if (!nib_sel) begin
        hi_nib = nib;
        nib_sel = 1'b1;
      end else begin
        b = {hi_nib[3:0], 4'h0} | nib;
        nib_sel = 1'b0;
        case (phase_q)
          InHeader: begin
            case (field_idx)
              9'd0: rec_count = b;
              9'd1: rec_offset[15:8] = b;
              9'd2: rec_offset[7:0] = b;
              default: rec_type = b;
            endcase
            if (field_idx >= 9'd3) finish_header();
            else field_idx = field_idx + 9'd1;
          end
          InData: begin
            expected_results.push_back('{kind: ihp_pkg::KindData,
                                         addr: (seg_base + {16'h0, rec_offset} +
                                                {23'h0, field_idx}) & ihp_pkg::AddrMask,
                                         data: b, base: '0, size: '0, last: 1'b0});
            field_idx = field_idx + 9'd1;
            if (field_idx >= {1'b0, rec_count}) phase_q = InTail;
          end
          default: begin
            if (field_idx == 9'd0) begin
              base_hi = b;
              field_idx = 9'd1;
            end else begin
              // The base moves only once both value bytes are in.
              val = {base_hi, b};
              if (rec_type == ihp_pkg::RecExtSeg)
                seg_base = ({16'h0, val} << 4) & ihp_pkg::AddrMask;
              else
                seg_base = ({16'h0, val} << 16) & ihp_pkg::AddrMask;
              phase_q = InTail;
            end
          end
        endcase
      end
    end

    if (eoi) begin
      if (lowest_start == ihp_pkg::AllOnes || highest_end == '0 ||
          highest_end <= lowest_start)
        expected_results.push_back('{kind: ihp_pkg::KindNoData, addr: '0, data: '0,
                                     base: '0, size: '0, last: 1'b0});
      else
        expected_results.push_back('{kind: ihp_pkg::KindExtent, addr: '0, data: '0,
                                     base: lowest_start, size: highest_end - lowest_start,
                                     last: 1'b0});
      clear_parser();
    end
    if (expected_results.size() > before_cnt)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  // Encode a nibble as a hex digit, upper or lower case at random.
  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 4'd10) return ihp_pkg::CharZero + {4'h0, n};
    return ($urandom_range(0, 1) ? ihp_pkg::CharUpA : ihp_pkg::CharLowA) +
           {4'h0, n - 4'd10};
  endfunction

  task automatic put_hex(logic [7:0] b);
    line_buf.push_back(hex_digit(b[7:4]));
    line_buf.push_back(hex_digit(b[3:0]));
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Close the line with LF, CR or CR LF.
  task automatic end_line();
    case ($urandom_range(0, 2))
      0: line_buf.push_back(ihp_pkg::CharLf);
      1: line_buf.push_back(ihp_pkg::CharCr);
      default: begin
        line_buf.push_back(ihp_pkg::CharCr);
        line_buf.push_back(ihp_pkg::CharLf);
      end
    endcase
  endtask

  // Move the assembled line into the request queue; flag end of input at one
  // position, or nowhere for a negative index.
  task automatic commit_line(int eoi_at);
    foreach (line_buf[i]) pending_chars.push_back('{ch: line_buf[i], eoi: (i == eoi_at)});
    line_buf.delete();
  endtask

  // Short directed opening: summaries with and without data, skipped lines,
  // every record type, address wrap, saturated extent, a zero count, odd digits,
  // trailing junk and an early line end.
  task automatic build_directed();
    put_text(":");
    commit_line(0);
    put_text("#skip");
    line_buf.push_back(ihp_pkg::CharLf);
    commit_line(-1);
    put_text(":00FFFF00");
    line_buf.push_back(ihp_pkg::CharLf);
    commit_line(9);
    put_text(":02000004FFFFjunk");
    line_buf.push_back(ihp_pkg::CharCr);
    line_buf.push_back(ihp_pkg::CharLf);
    commit_line(-1);
    put_text(":04FFFE00A55A00FF");
    line_buf.push_back(ihp_pkg::CharLf);
    commit_line(-1);
    put_text(":00100000");
    line_buf.push_back(ihp_pkg::CharLf);
    commit_line(-1);
    put_text(":00000001FF");
    line_buf.push_back(ihp_pkg::CharLf);
    commit_line(-1);
    put_text(":020000021234");
    line_buf.push_back(ihp_pkg::CharCr);
    commit_line(-1);
    // End of input lands on the digit that completes a data byte.
    put_text(":03001000zZ:0");
    line_buf.push_back(ihp_pkg::CharLf);
    commit_line(12);
  endtask

  // One random line: mostly well-formed records with random content, plus noise
  // lines, corrupted digits, truncated records and stray end-of-input flags.
  task automatic gen_random_line();
    int          pick;
    int          cnt;
    int          eoi_at;
    logic [7:0]  rtype;
    logic [7:0]  junk;
    logic [15:0] offset;
    logic [15:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) begin
        junk = 8'($urandom_range(0, 255));
        // Keep the line whole and make sure it is not a record.
        if (junk == ihp_pkg::CharLf || junk == ihp_pkg::CharCr ||
            (line_buf.size() == 0 && junk == ihp_pkg::CharColon))
          junk = junk ^ 8'h80;
        line_buf.push_back(junk);
      end
    end else begin
      line_buf.push_back(ihp_pkg::CharColon);
      pick = $urandom_range(0, 99);
      if (pick < 55) rtype = ihp_pkg::RecData;
      else if (pick < 67) rtype = ihp_pkg::RecExtSeg;
      else if (pick < 79) rtype = ihp_pkg::RecExtLin;
      else if (pick < 86) rtype = ihp_pkg::RecEof;
      else rtype = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
        0: offset = 16'h0000;
        1: offset = 16'hFFFF;
        2: offset = 16'hFFF0 | 16'($urandom_range(0, 15));
        default: offset = 16'($urandom_range(0, 65535));
      endcase
      if (rtype == ihp_pkg::RecData)
        cnt = ($urandom_range(0, 99) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 8);
      else if (rtype == ihp_pkg::RecExtSeg || rtype == ihp_pkg::RecExtLin)
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : 2;
      else
        cnt = $urandom_range(0, 3);
      put_hex(cnt[7:0]);
      put_hex(offset[15:8]);
      put_hex(offset[7:0]);
      put_hex(rtype);
      if (rtype == ihp_pkg::RecExtSeg || rtype == ihp_pkg::RecExtLin) begin
        case ($urandom_range(0, 4))
          0: val = 16'h0000;
          1: val = 16'hFFFF;
          default: val = 16'($urandom_range(0, 65535));
        endcase
        put_hex(val[15:8]);
        put_hex(val[7:0]);
      end else begin
        repeat (cnt) put_hex(8'($urandom_range(0, 255)));
      end
      put_hex(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
      if ($urandom_range(0, 19) == 0) begin
        // Drop a random character into the record, sometimes a colon.
        junk = ($urandom_range(0, 3) == 0) ? ihp_pkg::CharColon : 8'($urandom_range(0, 255));
        if (junk == ihp_pkg::CharLf || junk == ihp_pkg::CharCr) junk = junk ^ 8'h80;
        line_buf[$urandom_range(1, line_buf.size() - 1)] = junk;
      end
      if ($urandom_range(0, 12) == 0)
        line_buf = line_buf[0:$urandom_range(0, line_buf.size() - 2)];
    end
    end_line();
    eoi_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, line_buf.size() - 1) : -1;
    commit_line(eoi_at);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge, hold a stalled request.
  // ---------------------------------------------------------------------------
  int tx_gap = 0;
  bit tx_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && req_taken) begin
        // Draw the idle gap before the next request; flip between calm and
        // bursty spells now and then, and stay tight while the receiver holds off.
        if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
        tx_gap = (tx_calm || rx_hold) ? 0 : $urandom_range(0, MaxWait);
      end
      if (in_valid_i && !req_taken) begin
        // Hold the stalled request as it is.
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        character_i    <= pending_chars[0].ch;
        end_of_input_i <= pending_chars[0].eoi;
        in_valid_i     <= 1'b1;
        void'(pending_chars.pop_front());
      end else begin
        in_valid_i <= 1'b0;
        tx_drained = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall for a drawn number of cycles after each result.
  // ---------------------------------------------------------------------------
  int rx_wait = 0;
  bit rx_calm = 1'b0;

  always @(negedge clk_i) begin
    if (res_taken) begin
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, MaxWait);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall_i <= rx_hold || (rx_wait > 0);
  end

  // Long hold-off once traffic is flowing, so that the internal queue fills and
  // the block has to stall its requests.
  initial begin
    wait (requests_taken >= HoldAfter);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted result.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    hex_result_t want;
    logic        got_req;
    logic        got_res;
    got_req = rst_ni && in_valid_i && (in_stall_o === 1'b0);
    got_res = rst_ni && (out_valid_o === 1'b1) && !out_stall_i;
    req_taken <= got_req;
    res_taken <= got_res;
    // Predict first, so the check below never runs ahead of the stimulus.
    if (got_req) begin
      decode_hex_char(character_i, end_of_input_i);
      requests_taken++;
    end
    if (got_res) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d addr %h data %h",
                 $time, kind_o, byte_address_o, data_byte_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("byte_address", want.addr, byte_address_o);
        check_field("data_byte", 32'(want.data), 32'(data_byte_o));
        check_field("image_base", want.base, image_base_o);
        check_field("image_size", want.size, image_size_o);
        check_field("final_res", 32'(want.last), 32'(final_res_o));
      end
    end
  end

  // Watchdog: end the run if it goes far beyond the slowest legal run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stimulus, release reset, drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();
    build_directed();
    while (pending_chars.size() < RandomChars) gen_random_line();
    // Close the stream with a summary so the last image is reported too.
    line_buf.push_back(ihp_pkg::CharLf);
    commit_line(0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (tx_drained);
    wait (expected_results.size() == 0);
    // Let a request that causes no result work its way out before the final word.
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
